>>> hw/rtl/ssdt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// visited-state table. No dependencies.
`default_nettype none

package ssdt_pkg;

    // Table geometry
    localparam int MAX_WORDS   = 8;
    localparam int TABLE_DEPTH = 1024;

    // Field widths
    localparam int WORD_W    = 32;
    localparam int STEP_W    = 16;
    localparam int WC_W      = 4;
    localparam int OUTCOME_W = 2;
    localparam int OUT_IDX_W = 10;

    // Derived widths
    localparam int POS_W   = $clog2(MAX_WORDS + 1);
    localparam int SEL_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int TOT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int WADDR_W = $clog2(TABLE_DEPTH * MAX_WORDS);

    // Stream word widths, padded to whole bytes
    localparam int S_DATA_W = ((WORD_W + STEP_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OUTCOME_W + OUT_IDX_W + WORD_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - (OUTCOME_W + OUT_IDX_W + WORD_W);

    // Reset value of the word count register
    localparam logic [WC_W-1:0] WORD_COUNT_RESET = WC_W'(8);

    // Input function codes (carried on tuser)
    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_WORD  = 1'b1;

    // Lookup outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_APPEND  = 2'd0,
        OUT_DUP     = 2'd1,
        OUT_REPLACE = 2'd2,
        OUT_FULL    = 2'd3
    } outcome_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;       // empty the table and drop the candidate
        logic take_word;   // store an accepted mask word
        logic fold;        // form the fingerprint, restart the scan
        logic rd_entry;    // read fingerprint and steps of the current entry
        logic rd_word;     // read one stored word of the current entry
        logic next_entry;  // advance the entry pointer
        logic next_word;   // advance the word pointer
        logic set_found;   // record a full match at the current entry
        logic decide;      // settle the outcome, update fingerprint/steps
        logic wr_word;     // copy one candidate word into the table
        logic emit;        // load the result register, drop the candidate
    } ssdt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic table_empty; // no stored entries
        logic fp_match;    // read fingerprint equals candidate fingerprint
        logic word_match;  // read word equals candidate word
        logic word_last;   // word pointer at last word in use
        logic entry_last;  // entry pointer at last stored entry
        logic store;       // decision writes the candidate into the table
        logic wr_done;     // word pointer at last word slot
        logic out_busy;    // result register still held by the receiver
    } ssdt_sts_t;

    // Clamp the configured word count into 1..MAX_WORDS
    function automatic logic [POS_W-1:0] words_in_use(input logic [WC_W-1:0] wc);
        logic [POS_W-1:0] n;
        if (wc == '0) begin
            n = POS_W'(1);
        end else if (int'(wc) > MAX_WORDS) begin
            n = POS_W'(MAX_WORDS);
        end else begin
            n = POS_W'(wc);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssdt_ctrl.sv
// Sequencing state machine for the visited-state table.
// Depends on ssdt_pkg for the command and status structs.
`default_nettype none

module ssdt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    input  ssdt_pkg::ssdt_sts_t    sts,
    output ssdt_pkg::ssdt_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FOLD   = 9'b000000010,
        ST_RDFP   = 9'b000000100,
        ST_CHKFP  = 9'b000001000,
        ST_RDW    = 9'b000010000,
        ST_CHKW   = 9'b000100000,
        ST_DECIDE = 9'b001000000,
        ST_WRITE  = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == ssdt_pkg::FUNC_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.take_word = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_FOLD;
                        end
                    end
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = sts.table_empty ? ST_DECIDE : ST_RDFP;
            end
            ST_RDFP: begin
                cmd.rd_entry = 1'b1;
                state_next   = ST_CHKFP;
            end
            ST_CHKFP: begin
                if (sts.fp_match) begin
                    state_next = ST_RDW;
                end else if (sts.entry_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.next_entry = 1'b1;
                    state_next     = ST_RDFP;
                end
            end
            ST_RDW: begin
                cmd.rd_word = 1'b1;
                state_next  = ST_CHKW;
            end
            ST_CHKW: begin
                priority if (sts.word_match && sts.word_last) begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DECIDE;
                end else if (sts.word_match) begin
                    cmd.next_word = 1'b1;
                    state_next    = ST_RDW;
                end else if (sts.entry_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.next_entry = 1'b1;
                    state_next     = ST_RDFP;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.store ? ST_WRITE : ST_EMIT;
            end
            ST_WRITE: begin
                cmd.wr_word = 1'b1;
                if (sts.wr_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.next_word = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssdt_datapath.sv
// Datapath of the visited-state table: candidate buffer, entry memories,
// scan pointers, outcome logic and result register. Depends on ssdt_pkg.
`default_nettype none

module ssdt_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [ssdt_pkg::WC_W-1:0]         cfg_wdata,
    input  wire logic [ssdt_pkg::S_DATA_W-1:0]     s_tdata,
    input  ssdt_pkg::ssdt_cmd_t                    cmd,
    output ssdt_pkg::ssdt_sts_t                    sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ssdt_pkg::M_DATA_W-1:0]          m_tdata
);

    localparam int WORD_W = ssdt_pkg::WORD_W;
    localparam int STEP_W = ssdt_pkg::STEP_W;
    localparam int POS_W  = ssdt_pkg::POS_W;
    localparam int SEL_W  = ssdt_pkg::SEL_W;
    localparam int IDX_W  = ssdt_pkg::IDX_W;
    localparam int TOT_W  = ssdt_pkg::TOT_W;
    localparam int WA_W   = ssdt_pkg::WADDR_W;
    localparam int NW     = ssdt_pkg::MAX_WORDS;
    localparam int DEPTH  = ssdt_pkg::TABLE_DEPTH;

    // Entry memories
    logic [WORD_W-1:0] words_mem [DEPTH*NW];
    logic [WORD_W-1:0] fp_mem    [DEPTH];
    logic [STEP_W-1:0] steps_mem [DEPTH];

    // Configuration and candidate state
    logic [ssdt_pkg::WC_W-1:0] wc_reg;
    logic [WORD_W-1:0]         cand_reg [NW];
    logic [POS_W-1:0]          pos_reg;
    logic [WORD_W-1:0]         fp_reg;
    logic [STEP_W-1:0]         steps_reg;
    logic [POS_W-1:0]          n_reg;

    // Scan state
    logic [IDX_W-1:0]          idx_reg;
    logic [SEL_W-1:0]          sel_reg;
    logic [TOT_W-1:0]          total_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic [WORD_W-1:0]         fp_rd_reg;
    logic [STEP_W-1:0]         steps_rd_reg;
    logic [WORD_W-1:0]         word_rd_reg;
    ssdt_pkg::outcome_t        outcome_reg;

    // Result register
    logic                      m_tvalid_reg;
    logic [ssdt_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Combinational helpers
    logic [WORD_W-1:0]         in_word;
    logic [STEP_W-1:0]         in_steps;
    logic [WORD_W-1:0]         fold_fp;
    logic [WA_W-1:0]           rd_addr;
    logic [WA_W-1:0]           wr_addr;
    ssdt_pkg::outcome_t        dec_outcome;
    logic [IDX_W-1:0]          dec_slot;
    logic                      dec_store;
    logic                      dec_append;

    assign in_word  = s_tdata[WORD_W-1:0];
    assign in_steps = s_tdata[WORD_W +: STEP_W];

    // Fingerprint of the words in use
    always_comb begin
        fold_fp = '0;
        for (int k = 0; k < NW; k++) begin
            if (POS_W'(k) < n_reg) begin
                fold_fp = fold_fp ^ cand_reg[k];
            end
        end
    end

    assign rd_addr = WA_W'(idx_reg) * WA_W'(NW) + WA_W'(sel_reg);
    assign wr_addr = WA_W'(slot_reg) * WA_W'(NW) + WA_W'(sel_reg);

    // Outcome of the lookup
    always_comb begin
        dec_outcome = ssdt_pkg::OUT_FULL;
        dec_slot    = '0;
        dec_store   = 1'b0;
        dec_append  = 1'b0;
        priority if (found_reg && (steps_reg < steps_rd_reg)) begin
            dec_outcome = ssdt_pkg::OUT_REPLACE;
            dec_slot    = idx_reg;
            dec_store   = 1'b1;
        end else if (found_reg) begin
            dec_outcome = ssdt_pkg::OUT_DUP;
            dec_slot    = idx_reg;
        end else if (total_reg < TOT_W'(DEPTH)) begin
            dec_outcome = ssdt_pkg::OUT_APPEND;
            dec_slot    = IDX_W'(total_reg);
            dec_store   = 1'b1;
            dec_append  = 1'b1;
        end else begin
            dec_outcome = ssdt_pkg::OUT_FULL;
        end
    end

    // Status to the controller
    always_comb begin
        sts.table_empty = (total_reg == '0);
        sts.fp_match    = (fp_rd_reg == fp_reg);
        sts.word_match  = (word_rd_reg == cand_reg[sel_reg]);
        sts.word_last   = ((POS_W'(sel_reg) + POS_W'(1)) == n_reg);
        sts.entry_last  = ((TOT_W'(idx_reg) + TOT_W'(1)) == total_reg);
        sts.store       = dec_store;
        sts.wr_done     = (sel_reg == SEL_W'(NW - 1));
        sts.out_busy    = m_tvalid_reg && !m_tready;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg <= ssdt_pkg::WORD_COUNT_RESET;
        end else if (cfg_we) begin
            wc_reg <= cfg_wdata;
        end
    end

    // Candidate buffer: gather words, drop on clear or after a lookup
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear || cmd.emit) begin
            for (int k = 0; k < NW; k++) begin
                cand_reg[k] <= '0;
            end
            pos_reg <= '0;
            fp_reg  <= '0;
        end else if (cmd.take_word) begin
            if (pos_reg < POS_W'(NW)) begin
                cand_reg[SEL_W'(pos_reg)] <= in_word;
                pos_reg                   <= pos_reg + POS_W'(1);
            end
        end else if (cmd.fold) begin
            fp_reg <= fold_fp;
        end
    end

    // Latch step count and words in use on every word; the last word's values stand
    always_ff @(posedge aclk) begin
        if (cmd.take_word) begin
            steps_reg <= in_steps;
            n_reg     <= ssdt_pkg::words_in_use(wc_reg);
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            total_reg <= '0;
        end else if (cmd.decide && dec_append) begin
            total_reg <= total_reg + TOT_W'(1);
        end
    end

    // Scan pointers and match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            sel_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.fold) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end else if (cmd.next_entry) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.rd_entry || cmd.decide) begin
                sel_reg <= '0;
            end else if (cmd.next_word) begin
                sel_reg <= sel_reg + SEL_W'(1);
            end
        end
    end

    // Outcome and slot of the current lookup
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            outcome_reg <= dec_outcome;
            slot_reg    <= dec_slot;
        end
    end

    // Fingerprint and step memories
    always_ff @(posedge aclk) begin
        if (cmd.decide && dec_store) begin
            fp_mem[dec_slot]    <= fp_reg;
            steps_mem[dec_slot] <= steps_reg;
        end
        if (cmd.rd_entry) begin
            fp_rd_reg    <= fp_mem[idx_reg];
            steps_rd_reg <= steps_mem[idx_reg];
        end
    end

    // Word memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_word) begin
            words_mem[wr_addr] <= cand_reg[sel_reg];
        end
        if (cmd.rd_word) begin
            word_rd_reg <= words_mem[rd_addr];
        end
    end

    // Result register: load on emit, hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {{ssdt_pkg::M_PAD_W{1'b0}}, fp_reg,
                            ssdt_pkg::OUT_IDX_W'(slot_reg), outcome_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/search_state_dedup_table.sv
// Top level of the visited-state table: joins controller and datapath.
// Depends on ssdt_pkg, ssdt_ctrl and ssdt_datapath.
//
// Usage:
//   The slave stream carries one mask word per word. tuser selects the
//   function: 0 empties the table and drops a partial candidate, 1 delivers
//   a word. tlast marks the last word of a candidate and starts the lookup.
//   cfg_we/cfg_wdata set the number of words per state (reset value 8).
//   The master stream returns one word per lookup: outcome, entry index and
//   fingerprint. Clears and non-last words give no result.
// Lookup sequence:
//   Clears and non-last words keep the controller idle. A lookup reads the
//   stored entries one at a time through a single-port fingerprint memory
//   and a single-port word memory: per entry a read (RDFP) and a fingerprint
//   check (CHKFP), then on a fingerprint hit a read and compare per word in
//   use (RDW, CHKW), framed by fold, decide and emit states. Appending or
//   replacing copies all MAX_WORDS word slots into the table.
// Reset and stall:
//   Reset empties the table, clears the candidate and sets the word count to
//   8; there is no clearing pass. While a result waits on m_tready the block
//   still takes words; a further result waits in the controller until the
//   result register is free.
`default_nettype none

module search_state_dedup_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [ssdt_pkg::WC_W-1:0]      cfg_wdata,   // word_count
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ssdt_pkg::S_DATA_W-1:0]  s_tdata,     // mask_word, step_count
    input  wire logic                           s_tlast,     // word_last
    input  wire logic                           s_tuser,     // func
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ssdt_pkg::M_DATA_W-1:0]       m_tdata      // outcome, entry_index,
                                                             // fingerprint, zero pad
);

    ssdt_pkg::ssdt_cmd_t cmd;
    ssdt_pkg::ssdt_sts_t sts;

    ssdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssdt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> dv/tb_search_state_dedup_table.sv
// Self-checking bench for the visited-state table: directed and random
// candidates, clears and word-count changes against a scoreboard.
// Depends on ssdt_pkg and search_state_dedup_table.
import ssdt_pkg::*;

// One expected lookup result
typedef struct {
    outcome_t               outcome;
    bit [OUT_IDX_W-1:0]     entry_idx;
    bit [WORD_W-1:0]        fp;
} lookup_t;

// A state already sent, kept so that it can be offered again
typedef struct packed {
    logic [MAX_WORDS-1:0][WORD_W-1:0] words;
    logic [STEP_W-1:0]                steps;
} visited_state_t;

class visited_table_sb;
    bit [WORD_W-1:0] slot_words [TABLE_DEPTH][MAX_WORDS];
    bit [WORD_W-1:0] slot_fp    [TABLE_DEPTH];
    bit [STEP_W-1:0] slot_steps [TABLE_DEPTH];
    int unsigned     slot_total;
    bit [WORD_W-1:0] cand_words [MAX_WORDS];
    int unsigned     cand_pos;
    bit [WC_W-1:0]   word_count;
    lookup_t         pending_lookups [$];
    int              errors;

    function new();
        slot_total = 0;
        word_count = WORD_COUNT_RESET;
        errors     = 0;
        drop_candidate();
    endfunction

    function void drop_candidate();
        foreach (cand_words[j]) cand_words[j] = '0;
        cand_pos = 0;
    endfunction

    // Apply one accepted input word; queue the result of a lookup
    function void note_word(bit func, bit [WORD_W-1:0] w, bit last, bit [STEP_W-1:0] steps);
        int unsigned n, i, j, hit;
        bit [WORD_W-1:0] fp;
        bit found, same;
        lookup_t r;
        if (func == FUNC_CLEAR) begin
            slot_total = 0;
            drop_candidate();
            return;
        end
        if (cand_pos < MAX_WORDS) begin
            cand_words[cand_pos] = w;
            cand_pos++;
        end
        if (!last) return;
        // clamp the word count into 1..MAX_WORDS
        if (word_count == 0) n = 1;
        else if (word_count > MAX_WORDS) n = MAX_WORDS;
        else n = word_count;
        fp = '0;
        for (j = 0; j < n; j++) fp ^= cand_words[j];
        // first stored entry equal on fingerprint and every word in use
        found = 1'b0;
        hit   = 0;
        for (i = 0; i < slot_total && !found; i++) begin
            if (slot_fp[i] == fp) begin
                same = 1'b1;
                for (j = 0; j < n; j++)
                    if (slot_words[i][j] != cand_words[j]) same = 1'b0;
                if (same) begin
                    found = 1'b1;
                    hit   = i;
                end
            end
        end
        if (found) begin
            if (steps < slot_steps[hit]) begin
                r.outcome = OUT_REPLACE;
            end else begin
                r.outcome = OUT_DUP;
            end
        end else if (slot_total < TABLE_DEPTH) begin
            hit = slot_total;
            slot_total++;
            r.outcome = OUT_APPEND;
        end else begin
            hit = 0;
            r.outcome = OUT_FULL;
        end
        if (r.outcome == OUT_REPLACE || r.outcome == OUT_APPEND) begin
            for (j = 0; j < MAX_WORDS; j++) slot_words[hit][j] = cand_words[j];
            slot_fp[hit]    = fp;
            slot_steps[hit] = steps;
        end
        r.entry_idx = OUT_IDX_W'(hit);
        r.fp        = fp;
        pending_lookups.insert(pending_lookups.size(), r);
        drop_candidate();
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic [M_DATA_W-1:0] d);
        lookup_t e;
        logic [OUTCOME_W-1:0] oc;
        logic [OUT_IDX_W-1:0] ix;
        logic [WORD_W-1:0]    fp;
        oc = d[OUTCOME_W-1:0];
        ix = d[OUTCOME_W +: OUT_IDX_W];
        fp = d[OUTCOME_W + OUT_IDX_W +: WORD_W];
        if (pending_lookups.size() == 0) begin
            $error("result word with no lookup pending: %h", d);
            errors++;
            return;
        end
        e = pending_lookups.pop_front();
        if (oc !== e.outcome) begin
            $error("outcome: expected %0d (%s), got %0d", e.outcome, e.outcome.name(), oc);
            errors++;
        end
        if (ix !== e.entry_idx) begin
            $error("entry_index: expected %0d, got %0d", e.entry_idx, ix);
            errors++;
        end
        if (fp !== e.fp) begin
            $error("fingerprint: expected %h, got %h", e.fp, fp);
            errors++;
        end
    endfunction
endclass

module tb_search_state_dedup_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int SETTLE       = 24;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [WC_W-1:0]       cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    visited_table_sb sb = new();

    int unsigned     cycle_count = 0;
    bit              gaps_on     = 1'b1;
    int              burst_left  = 0;
    bit              hold_req    = 1'b0;
    int              hold_left   = 0;
    int              rx_mode     = 0;
    int              rx_mode_left = 0;
    int unsigned     rx_tick     = 0;
    int              random_items = 0;
    int              lookups_since_clear = 0;
    visited_state_t  pool [$];
    bit [WORD_W-1:0] dq [$];
    bit [WORD_W-1:0] fill_words [TABLE_DEPTH];
    bit [STEP_W-1:0] fill_steps [TABLE_DEPTH];

    search_state_dedup_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure: changing modes, plus a long hold on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        rx_tick++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_tick % 4) != 0;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check each result word; inputs only move at the rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Offer one word, hold it until taken, then maybe leave a gap
    task automatic send_item(bit func, bit [WORD_W-1:0] w, bit last, bit [STEP_W-1:0] steps);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tlast  <= last;
        s_tdata  <= S_DATA_W'({steps, w});
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        sb.note_word(func, w, last, steps);
        @(posedge aclk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_state(input bit [WORD_W-1:0] ws [$], input bit [STEP_W-1:0] steps);
        int i;
        for (i = 0; i < ws.size(); i++)
            send_item(FUNC_WORD, ws[i], i == ws.size() - 1, steps);
    endtask

    // Clear with junk in the ignored fields
    task automatic clear_table();
        send_item(FUNC_CLEAR, $urandom(), 1'($urandom_range(0, 1)), 16'($urandom()));
        lookups_since_clear = 0;
        pool.delete();
    endtask

    // Stop offering until every result is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_word_count(bit [WC_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.word_count = v;
    endtask

    // Build a candidate: a fresh state or a revisit, sometimes short or long
    task automatic send_random_candidate(input int n_eff);
        visited_state_t  pick, kept;
        bit [WORD_W-1:0] words [$];
        bit [WORD_W-1:0] tmp;
        bit [STEP_W-1:0] steps;
        int i, a, b, len, choice;
        choice = $urandom_range(0, 99);
        len    = n_eff;
        if (pool.size() != 0 && choice < 50) begin
            pick = pool[$urandom_range(0, pool.size() - 1)];
            for (i = 0; i < n_eff; i++) words.insert(words.size(), pick.words[i]);
            // swap two words: same fingerprint, possibly a different state
            if (choice < 12 && n_eff > 1) begin
                a = $urandom_range(0, n_eff - 1);
                b = $urandom_range(0, n_eff - 1);
                tmp      = words[a];
                words[a] = words[b];
                words[b] = tmp;
            end
            case ($urandom_range(0, 3))
                0: steps = pick.steps - 16'd1;
                1: steps = pick.steps;
                2: steps = pick.steps + 16'd1;
                default: steps = 16'($urandom());
            endcase
        end else begin
            for (i = 0; i < n_eff; i++)
                words.insert(words.size(),
                             ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom());
            steps  = 16'($urandom());
            choice = $urandom_range(0, 99);
            if (choice < 10 && n_eff > 1) begin
                len = $urandom_range(1, n_eff - 1);
                for (i = len; i < n_eff; i++) words[i] = '0;
            end else if (choice < 18) begin
                len = $urandom_range(n_eff + 1, MAX_WORDS + 2);
            end
        end
        kept.words = '0;
        for (i = 0; i < n_eff; i++) kept.words[i] = words[i];
        kept.steps = steps;
        // trim to what is actually sent, or append words beyond the count
        while (words.size() > len) void'(words.pop_back());
        while (words.size() < len) words.insert(words.size(), $urandom());
        send_state(words, steps);
        random_items += (len > MAX_WORDS) ? MAX_WORDS : len;
        lookups_since_clear++;
        pool.insert(pool.size(), kept);
        if (pool.size() > 16) void'(pool.pop_front());
    endtask

    initial begin
        int phase, wc, n_eff, k, i;
        bit [WORD_W-1:0] w;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: steps extremes on one state, short candidate at reset count
        dq = '{32'hFFFF_FFFF};
        send_state(dq, 16'hFFFF);
        send_state(dq, 16'hFFFF);
        send_state(dq, 16'h0000);
        send_state(dq, 16'h8000);
        clear_table();
        // more words than the candidate holds
        dq.delete();
        repeat (9) dq.insert(dq.size(), $urandom());
        send_state(dq, 16'($urandom()));
        // word count zero: second word takes no part
        drain();
        write_word_count(4'd0);
        dq = '{32'h0000_0000, 32'hA5A5_5A5A};
        send_state(dq, 16'd1);
        // word count above the maximum
        drain();
        write_word_count(4'd15);
        dq = '{32'h1234_5678};
        send_state(dq, 16'd2);
        // partial candidate dropped by a clear
        send_item(FUNC_WORD, 32'hDEAD_BEEF, 1'b0, 16'd3);
        clear_table();
        send_state(dq, 16'd4);

        // Random phases, each with its own word count
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            if ($urandom_range(0, 4) == 0) wc = $urandom_range(0, 15);
            else wc = $urandom_range(1, 4);
            write_word_count(WC_W'(wc));
            n_eff   = (wc == 0) ? 1 : (wc > MAX_WORDS) ? MAX_WORDS : wc;
            gaps_on = ($urandom_range(0, 3) != 0);
            clear_table();
            if (phase == 0) begin
                // long receiver hold while candidates keep coming
                hold_req = 1'b1;
                repeat (8) send_random_candidate(n_eff);
            end
            repeat ($urandom_range(80, 160)) begin
                k = $urandom_range(0, 99);
                if (lookups_since_clear >= 40 || k < 4) begin
                    clear_table();
                    random_items++;
                end else if (k < 8) begin
                    // broken candidate
                    repeat ($urandom_range(1, 3)) begin
                        send_item(FUNC_WORD, $urandom(), 1'b0, 16'($urandom()));
                        random_items++;
                    end
                    clear_table();
                    random_items++;
                end else begin
                    send_random_candidate(n_eff);
                end
            end
            phase++;
        end

        // Fill the table with single-word states, then run it full
        drain();
        gaps_on = 1'b1;
        write_word_count(4'd1);
        clear_table();
        for (i = 0; i < TABLE_DEPTH; i++) begin
            fill_words[i] = ($urandom() & 32'hFFFF_FC00) | WORD_W'(i);
            fill_steps[i] = 16'($urandom_range(1, 65535));
            dq = '{fill_words[i]};
            send_state(dq, fill_steps[i]);
        end
        w  = fill_words[TABLE_DEPTH / 2] ^ 32'h8000_0000;
        dq = '{w};
        send_state(dq, 16'd9);
        dq = '{fill_words[TABLE_DEPTH - 1]};
        send_state(dq, 16'hFFFF);
        dq = '{fill_words[7]};
        send_state(dq, 16'h0000);
        dq = '{~w};
        send_state(dq, 16'($urandom()));

        drain();
        if (sb.errors == 0 && sb.pending_lookups.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
